// ===== hw/rtl/egbe_pkg.sv =====
// Shared constants and types for the exp-Golomb byte encoder.
package egbe_pkg;

   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned USED_W    = 5;   // packed bit count, 0..31
   localparam int unsigned LEN_W     = 4;   // bit length of byte + 2^k, 1..9

   localparam logic [WORD_BITS-1:0] TERM_WORD = 32'd1;

   // result slots of one item, drained in this order
   localparam int unsigned SLOT_FULL = 0;
   localparam int unsigned SLOT_PART = 1;
   localparam int unsigned SLOT_TERM = 2;
   localparam int unsigned NUM_SLOTS = 3;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [WORD_BITS-1:0] full_word;
      logic [WORD_BITS-1:0] part_word;
      logic [WORD_BITS-1:0] next_pack;
      logic [USED_W-1:0]    next_used;
   } enc_result_type;

endpackage

// ===== hw/rtl/egbe_ifs.sv =====
// Channel interfaces: byte input, code word output, order register write.
interface egbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;
   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface egbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] code_word;
   logic        is_end;
   modport source (output valid, output code_word, output is_end, input ready);
   modport sink   (input valid, input code_word, input is_end, output ready);
endinterface

interface egbe_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] code_order;
   modport source (output valid, output code_order, input ready);
   modport sink   (input valid, input code_order, output ready);
endinterface

// ===== hw/rtl/egbe_encode.sv =====
// Combinational code builder: one byte into the packing word.
module egbe_encode (
   input  logic [7:0]                     data_byte,
   input  logic                           is_last,
   input  logic [2:0]                     code_order,
   input  logic [egbe_pkg::WORD_BITS-1:0] pack_word,
   input  logic [egbe_pkg::USED_W-1:0]    used_bits,
   output egbe_pkg::enc_result_type       result
);

   logic [8:0]                        value;
   logic [egbe_pkg::LEN_W-1:0]        bit_len;
   logic [4:0]                        code_len;
   logic [5:0]                        total;
   logic [5:0]                        shamt;
   logic [2*egbe_pkg::WORD_BITS-1:0]  acc;
   logic                              word_full;
   logic [egbe_pkg::WORD_BITS-1:0]    pack_next;

   assign value = {1'b0, data_byte} + (9'd1 << code_order);

   always_comb begin
      bit_len = '0;
      for (int i = 0; i < 9; i++) begin
         if (value[i]) begin
            bit_len = egbe_pkg::LEN_W'(i + 1);
         end
      end
   end

   // (len - 1 - k) zeros then the len bits of the value
   assign code_len = {bit_len, 1'b0} - 5'd1 - {2'b00, code_order};
   assign total    = {1'b0, used_bits} + {1'b0, code_len};
   assign shamt    = 6'(7'd64 - {1'b0, total});
   assign acc      = {pack_word, 32'h0} | (64'(value) << shamt);
   assign word_full = total[5];
   assign pack_next = word_full ? acc[31:0] : acc[63:32];

   always_comb begin
      result = '0;
      result.full_word = acc[63:32];
      result.part_word = pack_next;
      result.mask[egbe_pkg::SLOT_FULL] = word_full;
      result.mask[egbe_pkg::SLOT_PART] = is_last && (total[4:0] != '0);
      result.mask[egbe_pkg::SLOT_TERM] = is_last;
      if (is_last) begin
         result.next_pack = '0;
         result.next_used = '0;
      end else begin
         result.next_pack = pack_next;
         result.next_used = total[4:0];
      end
   end

endmodule

// ===== hw/rtl/egbe_outbuf.sv =====
// Result register: holds one item's words and hands them out one per transfer.
module egbe_outbuf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  egbe_pkg::enc_result_type result,
   output logic                     load_ok,
   egbe_rsp_if.source               rsp_port
);

   logic [egbe_pkg::NUM_SLOTS-1:0] mask_ff, mask_in, mask_drain;
   logic [egbe_pkg::WORD_BITS-1:0] full_ff, part_ff;
   logic                           xfer;

   assign rsp_port.valid = |mask_ff;
   assign xfer = rsp_port.valid && rsp_port.ready;

   always_comb begin
      if (mask_ff[egbe_pkg::SLOT_FULL]) begin
         rsp_port.code_word = full_ff;
      end else if (mask_ff[egbe_pkg::SLOT_PART]) begin
         rsp_port.code_word = part_ff;
      end else begin
         rsp_port.code_word = egbe_pkg::TERM_WORD;
      end
      rsp_port.is_end = mask_ff == (3'b001 << egbe_pkg::SLOT_TERM);
   end

   // clear lowest pending slot on transfer
   assign mask_drain = xfer ? (mask_ff & (mask_ff - 3'd1)) : mask_ff;
   assign load_ok    = mask_drain == '0;
   assign mask_in    = load ? result.mask : mask_drain;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         full_ff <= result.full_word;
         part_ff <= result.part_word;
      end
   end

endmodule

// ===== hw/rtl/exp_golomb_byte_encoder.sv =====
// Top level: order-k exp-Golomb byte encoder packing codes into 32-bit words.
// Path: a byte is registered in the input stage, encoded combinationally and loaded into the result register.
// Throughput: one byte per cycle while the result port accepts words; a last byte fills
//   the result register with up to 3 words (filled word, partial word, terminator), one word a cycle.
// Reset: synchronous; clears the order to 0, the packing word and both stages.
module exp_golomb_byte_encoder (
   input  logic       clock,
   input  logic       reset,
   egbe_req_if.sink   req_port,
   egbe_rsp_if.source rsp_port,
   egbe_csr_if.sink   csr_port
);

   logic                           in_valid_ff;
   logic [7:0]                     byte_ff;
   logic                           last_ff;
   logic [2:0]                     code_order_ff;
   logic [egbe_pkg::WORD_BITS-1:0] pack_ff;
   logic [egbe_pkg::USED_W-1:0]    used_ff;
   logic                           load_ok, advance;
   egbe_pkg::enc_result_type       result;

   assign csr_port.ready = 1'b1;
   assign advance        = in_valid_ff && load_ok;
   assign req_port.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_order_ff <= '0;
      end else if (csr_port.valid) begin
         code_order_ff <= csr_port.code_order;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         in_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         byte_ff <= req_port.data_byte;
         last_ff <= req_port.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_ff <= '0;
         used_ff <= '0;
      end else if (advance) begin
         pack_ff <= result.next_pack;
         used_ff <= result.next_used;
      end
   end

   egbe_encode u_encode (
      .data_byte  (byte_ff),
      .is_last    (last_ff),
      .code_order (code_order_ff),
      .pack_word  (pack_ff),
      .used_bits  (used_ff),
      .result     (result)
   );

   egbe_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .load_ok  (load_ok),
      .rsp_port (rsp_port)
   );

endmodule

// ===== hw/rtl/egbe_checker.sv =====
// Port-level checks for the encoder, attached by bind.
module egbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_code_word,
   input logic        rsp_is_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_word) && $stable(rsp_is_end))
      else $error("result changed while stalled");

   a_end_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_code_word == 32'd1)
      else $error("end word is not the terminator");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind exp_golomb_byte_encoder egbe_checker u_egbe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_code_word (rsp_port.code_word),
   .rsp_is_end    (rsp_port.is_end)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the exp-Golomb byte encoder: predicts packed code words per byte.
`timescale 1ns / 100ps

module tb;

   localparam int unsigned STALL_LIMIT   = 200;  // cycles with no transfer at all
   localparam int unsigned SETTLE_CYCLES = 8;    // quiet time before an order write
   localparam int unsigned MAX_REPORTS   = 40;

   typedef struct {
      logic [7:0] data_byte;
      logic       is_last;
   } byte_item_type;

   typedef struct packed {
      logic [31:0] code_word;
      logic        is_end;
   } code_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   egbe_req_if req_if ();
   egbe_rsp_if rsp_if ();
   egbe_csr_if csr_if ();

   exp_golomb_byte_encoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   always #1 clock = ~clock;

   byte_item_type  pending_bytes[$];
   code_word_type  expected_words[$];

   // encoder state as predicted
   logic [2:0]  cur_order   = 3'd0;
   logic [31:0] packed_bits = 32'd0;
   int unsigned fill_count  = 0;

   int unsigned items_queued = 0;
   int unsigned items_sent   = 0;
   int unsigned err_count    = 0;
   int unsigned stall_cycles = 0;
   bit          idle_on      = 1'b0;
   int unsigned gap_left     = 0;
   int unsigned hold_left    = 0;
   byte_item_type next_item;

   task automatic report_mismatch(input string msg);
      if (err_count < MAX_REPORTS)
         $display("MISMATCH @%0t: %s", $time, msg);
      err_count++;
   endtask

   // Append the code of one byte to the packing word; queue any words it completes.
   task automatic encode_byte(input logic [7:0] b, input logic last);
      logic [8:0]  v;
      logic [63:0] acc;
      int unsigned len;
      int unsigned n;
      int unsigned total;
      v = {1'b0, b} + (9'd1 << cur_order);
      len = 0;
      for (int i = 0; i < 9; i++)
         if (v[i]) len = i + 1;
      n = 2 * len - 1 - cur_order;
      total = fill_count + n;
      acc = {packed_bits, 32'd0} | (64'(v) << (64 - total));
      if (total >= 32) begin
         expected_words.push_back(code_word_type'{acc[63:32], 1'b0});
         packed_bits = acc[31:0];
         fill_count = total - 32;
      end else begin
         packed_bits = acc[63:32];
         fill_count = total;
      end
      if (last) begin
         if (fill_count != 0)
            expected_words.push_back(code_word_type'{packed_bits, 1'b0});
         expected_words.push_back(code_word_type'{egbe_pkg::TERM_WORD, 1'b1});
         packed_bits = 32'd0;
         fill_count = 0;
      end
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            encode_byte(req_if.data_byte, req_if.is_last);
            items_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
               gap_left = $urandom_range(1, 11) - 1;
               req_if.valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               next_item = pending_bytes.pop_front();
               req_if.valid     <= 1'b1;
               req_if.data_byte <= next_item.data_byte;
               req_if.is_last   <= next_item.is_last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // word monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %08h end %0b",
                                         rsp_if.code_word, rsp_if.is_end));
            end else begin
               if (rsp_if.code_word !== expected_words[0].code_word)
                  report_mismatch($sformatf("code_word %08h, expected %08h",
                                            rsp_if.code_word, expected_words[0].code_word));
               if (rsp_if.is_end !== expected_words[0].is_end)
                  report_mismatch($sformatf("is_end %0b, expected %0b on word %08h",
                                            rsp_if.is_end, expected_words[0].is_end,
                                            expected_words[0].code_word));
               void'(expected_words.pop_front());
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 6) == 0) begin
            hold_left = $urandom_range(1, 11) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                   (csr_if.valid && csr_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("exp_golomb_byte_encoder verification failed");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      pending_bytes.push_back(byte_item_type'{b, last});
      items_queued++;
   endtask

   // wait until every byte is taken and every word has come back
   task automatic settle();
      do @(posedge clock);
      while (items_sent != items_queued || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_code_order(input logic [2:0] k);
      csr_if.valid      <= 1'b1;
      csr_if.code_order <= k;
      do @(posedge clock);
      while (!csr_if.ready);
      cur_order = k;
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      int unsigned sel;
      logic [7:0]  b;
      req_if.valid      = 1'b0;
      req_if.data_byte  = 8'd0;
      req_if.is_last    = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.code_order = 3'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      // order 0 after reset: single-byte stream, exact fill ending empty,
      // one byte giving full + partial + terminator, then bits left packed
      push_byte(8'd0, 1'b1);
      push_byte(8'd255, 1'b0);
      push_byte(8'd127, 1'b1);
      push_byte(8'd255, 1'b0);
      push_byte(8'd255, 1'b1);
      push_byte(8'd1, 1'b0);
      push_byte(8'd2, 1'b0);
      push_byte(8'd3, 1'b0);
      push_byte(8'd128, 1'b0);
      push_byte(8'd200, 1'b0);
      settle();

      // order change with a partial word pending
      set_code_order(3'd7);
      push_byte(8'd0, 1'b0);
      push_byte(8'd255, 1'b0);
      push_byte(8'd128, 1'b0);
      push_byte(8'd255, 1'b1);
      push_byte(8'd0, 1'b0);
      push_byte(8'd1, 1'b0);
      push_byte(8'd127, 1'b0);
      push_byte(8'd100, 1'b1);
      settle();

      set_code_order(3'd3);
      push_byte(8'd5, 1'b0);
      push_byte(8'd250, 1'b0);
      push_byte(8'd7, 1'b1);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0)
            set_code_order(3'd0);
         else if (phase == 6)
            set_code_order(3'd7);
         else
            set_code_order(3'($urandom_range(0, 7)));
         idle_on = (phase != 7) && ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 24; i++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
               b = 8'd0;
            else if (sel == 1)
               b = 8'd255;
            else
               b = 8'($urandom_range(0, 255));
            push_byte(b, (phase == 7 && i == 23) || ($urandom_range(0, 9) == 0));
         end
         settle();
      end

      if (expected_words.size() != 0)
         report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));
      if (err_count == 0)
         $display("exp_golomb_byte_encoder verification clean");
      else
         $display("exp_golomb_byte_encoder verification failed");
      $finish;
   end

endmodule
